[rtl/ssr_pkg.sv]
package ssr_pkg;

	// Width of the length fields and of the command byte count, fixed by the register map.
	localparam int LEN_W = 4;

	// Largest number of result bytes one input transaction can cause.
	localparam int CMD_BYTES = 8;
	localparam int CMD_IDX_W = 3;

	// Configuration port geometry.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_BYTES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBST_BYTES   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBST_LENGTH  = 3'd3;

	// Command queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// One command: the bytes to emit, how many, and whether the text ends here.
	// A count of zero with last set asks for a bare end marker.
	typedef struct packed {
		logic [CMD_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0]          cnt;
		logic                      last;
	} cmd_t;

endpackage

[rtl/stream_search_replace.sv]
// Streaming search and replace over a byte text. Bytes enter one per
// transaction with a last mark; every non-overlapping occurrence of the
// configured pattern, found left to right, leaves as the configured
// substitute, and pending bytes are flushed at the end of the text, with a
// bare end marker when nothing else is given. A new input transaction is
// taken every cycle while the four-entry command queue between the
// classifying front part and the output back part has room. The back part
// delivers one result per cycle from its output register while res_stall is
// low (a bare end marker counts as one result); that sets the sustained rate
// when substitutes expand the text. Configuration is written through a plain
// write port, by the user only while the block is idle, which the block does
// not enforce; writing the pattern length drops any pending window bytes.
module stream_search_replace #(
	parameter int PATTERN_MAX = 8,
	parameter int SUBST_MAX = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     in_byte,
	input  logic                           in_last,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [7:0]                     out_byte,
	output logic                           out_valid,
	output logic                           out_last
);

	logic          in_fire;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;
	ssr_pkg::cmd_t push_cmd;
	ssr_pkg::cmd_t head;

	// Input is held off only while the command queue is full.
	assign in_stall = q_full;
	assign in_fire  = in_valid && !q_full;

	ssr_front #(
		.PATTERN_MAX(PATTERN_MAX),
		.SUBST_MAX(SUBST_MAX)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_fire(in_fire),
		.in_byte(in_byte),
		.in_last(in_last),
		.push(push),
		.cmd(push_cmd)
	);

	ssr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.full(q_full),
		.empty(q_empty),
		.head(head)
	);

	ssr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(q_empty),
		.head(head),
		.pop(pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_byte(out_byte),
		.out_valid(out_valid),
		.out_last(out_last)
	);

endmodule

[rtl/ssr_front.sv]
module ssr_front #(
	parameter int PATTERN_MAX = 8,
	parameter int SUBST_MAX = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ssr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_fire,
	input  logic [7:0]                        in_byte,
	input  logic                              in_last,
	output logic                              push,
	output ssr_pkg::cmd_t                     cmd
);

	localparam int LW = ssr_pkg::LEN_W;

	logic [63:0]   search_bytes_q;
	logic [LW-1:0] search_len_q;
	logic [63:0]   subst_bytes_q;
	logic [LW-1:0] subst_len_q;

	logic [7:0]    win_q [PATTERN_MAX];
	logic [LW-1:0] win_cnt_q;

	logic [LW-1:0] eff_l;
	logic [LW-1:0] eff_s;
	logic [LW-1:0] n;
	logic [7:0]    buf_b [PATTERN_MAX];
	logic          full;
	logic          match;
	logic [LW-1:0] cnt_d;

	// Configuration registers; a new pattern length drops the pending window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_bytes_q <= '0;
			search_len_q   <= LW'(1);
			subst_bytes_q  <= '0;
			subst_len_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ssr_pkg::CFG_SEARCH_BYTES:  search_bytes_q <= cfg_data[63:0];
				ssr_pkg::CFG_SEARCH_LENGTH: search_len_q   <= cfg_data[LW-1:0];
				ssr_pkg::CFG_SUBST_BYTES:   subst_bytes_q  <= cfg_data[63:0];
				ssr_pkg::CFG_SUBST_LENGTH:  subst_len_q    <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// Effective lengths: a zero pattern length acts as one, oversized values saturate.
	always_comb begin
		if (search_len_q == '0) begin
			eff_l = LW'(1);
		end else if (search_len_q > LW'(PATTERN_MAX)) begin
			eff_l = LW'(PATTERN_MAX);
		end else begin
			eff_l = search_len_q;
		end
		if (subst_len_q > LW'(SUBST_MAX)) begin
			eff_s = LW'(SUBST_MAX);
		end else begin
			eff_s = subst_len_q;
		end
	end

	// Pending bytes followed by the new byte, and the pattern compare.
	always_comb begin
		if (win_cnt_q > eff_l - LW'(1)) begin
			n = eff_l - LW'(1);
		end else begin
			n = win_cnt_q;
		end
		for (int i = 0; i < PATTERN_MAX; i++) begin
			buf_b[i] = (LW'(i) < n) ? win_q[i] : in_byte;
		end
		full = (n == eff_l - LW'(1));
		match = full;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (LW'(i) < eff_l && buf_b[i] != search_bytes_q[8*i +: 8]) begin
				match = 1'b0;
			end
		end
	end

	// Classify the transaction into at most one command for the back part.
	always_comb begin
		if (match) begin
			cnt_d = eff_s;
		end else if (full) begin
			cnt_d = in_last ? eff_l : LW'(1);
		end else begin
			cnt_d = in_last ? n + LW'(1) : '0;
		end
		for (int j = 0; j < ssr_pkg::CMD_BYTES; j++) begin
			if (match) begin
				cmd.bytes[j] = subst_bytes_q[8*j +: 8];
			end else if (j < PATTERN_MAX) begin
				cmd.bytes[j] = buf_b[j];
			end else begin
				cmd.bytes[j] = 8'd0;
			end
		end
		cmd.cnt  = cnt_d;
		cmd.last = in_last;
		push = in_fire && (cnt_d != '0 || in_last);
	end

	// Window count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q <= '0;
		end else if (cfg_we && cfg_index == ssr_pkg::CFG_SEARCH_LENGTH) begin
			win_cnt_q <= '0;
		end else if (in_fire) begin
			if (in_last || match) begin
				win_cnt_q <= '0;
			end else if (full) begin
				win_cnt_q <= eff_l - LW'(1);
			end else begin
				win_cnt_q <= n + LW'(1);
			end
		end
	end

	// Window bytes; on a miss with a full window the oldest byte leaves.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < PATTERN_MAX - 1; i++) begin
				win_q[i] <= full ? buf_b[i+1] : buf_b[i];
			end
			win_q[PATTERN_MAX-1] <= buf_b[PATTERN_MAX-1];
		end
	end

endmodule

[rtl/ssr_queue.sv]
module ssr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssr_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output ssr_pkg::cmd_t head
);

	ssr_pkg::cmd_t                 mem_q [ssr_pkg::QDEPTH];
	logic [ssr_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ssr_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ssr_pkg::QCNT_W-1:0]    cnt_q;

	assign full  = (cnt_q == ssr_pkg::QCNT_W'(ssr_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ssr_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ssr_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + ssr_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - ssr_pkg::QCNT_W'(1);
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[rtl/ssr_back.sv]
module ssr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  ssr_pkg::cmd_t head,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [7:0]    out_byte,
	output logic          out_valid,
	output logic          out_last
);

	logic [ssr_pkg::CMD_IDX_W-1:0] idx_q;
	logic                          res_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          out_valid_q;
	logic                          out_last_q;
	logic                          load;
	logic                          final_item;

	// Load the next result when the output register is free or being taken.
	assign load = !empty && (!res_valid_q || !res_stall);
	assign final_item = (head.cnt == '0) ||
		({1'b0, idx_q} == head.cnt - ssr_pkg::LEN_W'(1));
	assign pop = load && final_item;

	// Walk through the bytes of the head command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= final_item ? '0 : idx_q + ssr_pkg::CMD_IDX_W'(1);
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= (head.cnt == '0) ? 8'd0 : head.bytes[idx_q];
			out_valid_q <= (head.cnt != '0);
			out_last_q  <= head.last && final_item;
		end
	end

	assign res_valid = res_valid_q;
	assign out_byte  = out_byte_q;
	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;

endmodule
